// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and bit functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef logic [7:0][31:0] vars_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_LOAD,
      S_ROUND,
      S_ADD,
      S_OUT
   } state_type;

   localparam int BlockWords = 16;
   localparam int Rounds     = 64;
   localparam logic [7:0] PadByte = 8'h80;

   localparam vars_type InitHash = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

endpackage

// ===== hdl/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// One SHA-256 compression round on the working variables a..h.
// ----------------------------------------------------------------------------
module sha_round
   import sha_pkg::*;
(
   input  vars_type    vars_cur,
   input  logic [31:0] round_k,
   input  logic [31:0] round_w,
   output vars_type    vars_nxt
);

   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] choose;
   logic [31:0] major;

   // compute the two temporaries
   assign choose = (vars_cur[4] & vars_cur[5]) ^ (~vars_cur[4] & vars_cur[6]);
   assign major  = (vars_cur[0] & vars_cur[1]) ^ (vars_cur[0] & vars_cur[2])
                 ^ (vars_cur[1] & vars_cur[2]);
   assign t1 = vars_cur[7] + big_sigma1(vars_cur[4]) + choose + round_k + round_w;
   assign t2 = big_sigma0(vars_cur[0]) + major;

   // rotate the variables
   always_comb begin
      vars_nxt[7] = vars_cur[6];
      vars_nxt[6] = vars_cur[5];
      vars_nxt[5] = vars_cur[4];
      vars_nxt[4] = vars_cur[3] + t1;
      vars_nxt[3] = vars_cur[2];
      vars_nxt[2] = vars_cur[1];
      vars_nxt[1] = vars_cur[0];
      vars_nxt[0] = t1 + t2;
   end

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256: packs bytes into a block memory, compresses, pads and
// returns the eight digest words.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  req_    | in        | one byte and/or end-of-message mark
//  rsp_    | out       | one digest word, H0 first, eight per message
//
//  A byte is taken every cycle while the block fills. A full block holds
//  req_stall high through one memory read set-up, 64 rounds on the single
//  round unit and one hash update. An end transaction pads at one byte per
//  cycle to the block end, one or two compressions, then eight rsp_ transactions.
//  Reset is synchronous; rsp_stall holds the current digest word.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_position,
   output logic        rsp_final_word
);

   state_type   state_ff, state_in;
   vars_type    hash_ff, hash_in;
   vars_type    vars_ff, vars_in, vars_rnd;
   logic [31:0] w_ff [BlockWords];
   logic [31:0] mem [BlockWords];
   logic [31:0] rd_ff;
   logic [3:0]  rd_addr;
   logic [31:0] word_ff, word_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] bytes_ff, bytes_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  pos_ff, pos_in;
   logic        pad_ff, pad_in;
   logic        sent80_ff, sent80_in;
   logic        lenok_ff, lenok_in;
   logic        fin_ff, fin_in;
   logic        put;
   logic [7:0]  put_byte;
   logic [63:0] bit_len;
   logic [31:0] w_t;
   logic        req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign bit_len = {bytes_ff, 3'b000};
   assign word_in = {word_ff[23:0], put_byte};

   // pick the current schedule word
   assign w_t = (round_ff < 6'(BlockWords)) ? rd_ff
              : (w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]));

   sha_round u_round (
      .vars_cur (vars_ff),
      .round_k  (RoundK[round_ff]),
      .round_w  (w_t),
      .vars_nxt (vars_rnd)
   );

   // next state and datapath control
   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      vars_in   = vars_ff;
      fill_in   = fill_ff;
      bytes_in  = bytes_ff;
      round_in  = round_ff;
      pos_in    = pos_ff;
      pad_in    = pad_ff;
      sent80_in = sent80_ff;
      lenok_in  = lenok_ff;
      fin_in    = fin_ff;
      put       = 1'b0;
      put_byte  = req_data_byte;
      rd_addr   = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_acc) begin
               if (req_byte_present) begin
                  put      = 1'b1;
                  fill_in  = fill_ff + 6'd1;
                  bytes_in = bytes_ff + 61'd1;
               end
               if (req_end_of_message) begin
                  pad_in    = 1'b1;
                  sent80_in = 1'b0;
                  lenok_in  = 1'b0;
                  fin_in    = 1'b0;
               end
               if (req_byte_present && fill_ff == 6'd63) begin
                  state_in = S_LOAD;
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            put     = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (!sent80_ff) begin
               put_byte  = PadByte;
               sent80_in = 1'b1;
               lenok_in  = (fill_ff < 6'd56);
            end else if (lenok_ff && fill_ff >= 6'd56) begin
               put_byte = bit_len[6'(7 - fill_ff[2:0]) * 8 +: 8];
            end else begin
               put_byte = 8'h00;
            end
            if (fill_ff == 6'd63) begin
               fin_in   = lenok_ff || (!sent80_ff && 1'b0);
               lenok_in = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            rd_addr  = '0;
            vars_in  = hash_ff;
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            rd_addr  = 4'(round_ff + 6'd1);
            vars_in  = vars_rnd;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(Rounds - 1)) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            if (fin_ff) begin
               pos_in   = '0;
               state_in = S_OUT;
            end else if (pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_acc) begin
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd7) begin
                  hash_in  = InitHash;
                  fill_in  = '0;
                  bytes_in = '0;
                  pad_in   = 1'b0;
                  fin_in   = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_digest_word   = hash_ff[pos_ff];
   assign rsp_word_position = pos_ff;
   assign rsp_final_word    = (pos_ff == 3'd7);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         hash_ff   <= InitHash;
         fill_ff   <= '0;
         bytes_ff  <= '0;
         round_ff  <= '0;
         pos_ff    <= '0;
         pad_ff    <= 1'b0;
         sent80_ff <= 1'b0;
         lenok_ff  <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hash_ff   <= hash_in;
         fill_ff   <= fill_in;
         bytes_ff  <= bytes_in;
         round_ff  <= round_in;
         pos_ff    <= pos_in;
         pad_ff    <= pad_in;
         sent80_ff <= sent80_in;
         lenok_ff  <= lenok_in;
         fin_ff    <= fin_in;
      end
   end

   // datapath registers: packer, variables, schedule window
   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      if (put) begin
         word_ff <= word_in;
      end
      if (state_ff == S_ROUND) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[BlockWords - 1] <= w_t;
      end
   end

   // block memory: write a word when its last byte lands, read one ahead
   always_ff @(posedge clock) begin
      if (put && fill_ff[1:0] == 2'd3) begin
         mem[fill_ff[5:2]] <= word_in;
      end
      rd_ff <= mem[rd_addr];
   end

   // results appear only while the digest is being read out
   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_OUT)
      else $error("rsp_valid outside readout");

   // input and output sides never open together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall))
      else $error("input accepted during readout");

   // hash returns to initial values after the last word
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_final_word) |=> (hash_ff == InitHash && fill_ff == 6'd0))
      else $error("hash not reinitialized");

   // rounds start from zero after each load
   a_round_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |=> round_ff == 6'd0)
      else $error("round counter not cleared");

endmodule

// ===== tb/tb_sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Drives byte transactions and end marks into the SHA-256 stream hasher and
// checks every digest word against an in-bench SHA-256 model, under random
// idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
   import sha_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  position;
      logic        final_flag;
   } digest_item_type;

   typedef struct {
      byte_item_type   item;
      logic            has_digest;
      logic [31:0]     h0;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_position;
   logic        rsp_final_word;

   sha256_stream_hasher dut (.*);

   always #4 clock = ~clock;

   // model state
   logic [31:0] hash_state [8];
   logic [31:0] block_buf [16];
   logic [5:0]  fill_count;
   logic [60:0] byte_count;
   digest_item_type digest_queue [$];
   int  error_count = 0;
   int  send_idle = 7;
   int  recv_idle = 70;
   int  items_sent = 0;
   bit  hold_recv = 0;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic run_compression();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_buf[i];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
              + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic place_byte(logic [7:0] b);
      int wi;
      int sh;
      wi = fill_count[5:2];
      sh = 24 - 8 * fill_count[1:0];
      if (fill_count[1:0] == 0) block_buf[wi] = 32'(b) << sh;
      else block_buf[wi] |= 32'(b) << sh;
      fill_count++;
   endtask

   task automatic clear_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
      fill_count = 0;
      byte_count = 0;
   endtask

   // advance the model by one accepted transaction
   task automatic predict_digest(byte_item_type it);
      logic [63:0] bit_len;
      bit spill;
      if (it.present) begin
         place_byte(it.data);
         byte_count++;
         if (fill_count == 0) run_compression();
      end
      if (!it.last) return;
      bit_len = {byte_count, 3'b000};
      spill = fill_count >= 56;
      place_byte(PadByte);
      while (fill_count[1:0] != 0) place_byte(8'h00);
      if (fill_count != 0)
         for (int i = fill_count[5:2]; i < 16; i++) block_buf[i] = '0;
      if (spill) begin
         run_compression();
         for (int i = 0; i < 16; i++) block_buf[i] = '0;
      end
      block_buf[14] = bit_len[63:32];
      block_buf[15] = bit_len[31:0];
      run_compression();
      for (int i = 0; i < 8; i++)
         digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
      clear_hash();
   endtask

   // send one transaction and wait for its acceptance; drop valid only on idle
   task automatic send_item(byte_item_type it);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= it.data;
      req_byte_present <= it.present;
      req_end_of_message <= it.last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_digest(it);
   endtask

   task automatic send_message(int len, bit end_byte);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data = 8'($urandom);
         it.present = 1'b1;
         it.last = end_byte && (i == len - 1);
         send_item(it);
      end
      if (!end_byte || len == 0) send_item('{8'($urandom), 1'b0, 1'b1});
   endtask

   // randomize result stall, with one long hold-off when asked
   always @(posedge clock) begin
      if (hold_recv) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // check every accepted digest word
   always @(posedge clock) begin
      digest_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected digest word %h", rsp_digest_word);
         end else begin
            want = digest_queue.pop_front();
            if (want !== {rsp_digest_word, rsp_word_position, rsp_final_word}) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                     want.word, want.position, want.final_flag,
                     rsp_digest_word, rsp_word_position, rsp_final_word);
            end
         end
      end
   end

   vector_type directed [] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, 32'he3b0c442},  // empty message
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, 32'h0},         // idle item, ignored
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, 32'hba7816bf},  // "abc", byte on end
      '{'{8'hff, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'hff, 1'b0, 1'b1}, 1'b0, 32'h0}           // end with ignored byte
   };

   int phase_start;

   initial begin
      clear_hash();
      for (int i = 0; i < 16; i++) block_buf[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; known digests also checked by their first word
      foreach (directed[k]) begin
         send_item(directed[k].item);
         if (directed[k].has_digest && digest_queue[digest_queue.size()-8].word
             !== directed[k].h0) begin
            error_count++;
            $display("known digest row %0d: model gives %h", k,
               digest_queue[digest_queue.size()-8].word);
         end
      end
      // padding overflow and block boundary lengths
      send_message(55, 0);
      send_message(56, 1);
      send_message(63, 0);
      send_message(64, 1);

      // long receiver hold-off while the bench keeps offering bytes
      hold_recv = 1;
      fork
         begin repeat (400) @(posedge clock); hold_recv = 0; end
         begin
            send_message(3, 0);
            send_message(70, 0);
            send_message(5, 1);
         end
      join

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
         recv_idle = (phase == 0) ? 70 : (phase == 1) ? 7 : 0;
         phase_start = items_sent;
         while (items_sent - phase_start < 35) begin
            case ($urandom_range(9))
               0: send_message($urandom_range(120, 50), $urandom_range(1));
               1: send_item('{8'($urandom), 1'b0, 1'b0});
               default: send_message($urandom_range(20), $urandom_range(1));
            endcase
         end
      end
      req_valid <= 1'b0;

      while (digest_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
